// File: rtl/page_framebuffer_text_pixel_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Page framebuffer text and pixel engine: assertion macros
// Shared property shorthands for the checker of the framebuffer engine.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_TEXT_PIXEL_ENGINE_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_TEXT_PIXEL_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framebuffer engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framebuffer engine check failed");

`endif

// File: rtl/pfte_pkg.sv
// ----------------------------------------------------------------------------
// Page framebuffer text and pixel engine package
// Command and result types, the internal job format and the 5x8 font.
// ----------------------------------------------------------------------------
package pfte_pkg;

    localparam int ADDR_MAX_W  = 12;
    localparam int GLYPH_IDX_W = 7;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd122;
    localparam logic [2:0] GLYPH_COLS = 3'd5;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_READ  = 2'd3
    } t_command;

    typedef struct packed {
        t_command   command;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] page;
        logic [7:0] character;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_ok;
    } t_result;

    typedef struct packed {
        t_command               op;
        logic [ADDR_MAX_W-1:0]  addr;
        logic [7:0]             mask;
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [2:0]             ncols;
        logic                   addr_ok;
    } t_job;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PIX_WR,
        BK_RD_DONE,
        BK_CHAR
    } t_back_state;

    // Glyph columns packed with the leftmost column in the top byte.
    function automatic logic [39:0] font_row(input logic [GLYPH_IDX_W-1:0] idx);
        logic [39:0] row;
        case (idx)
            7'd0:    row = 40'h0000000000;
            7'd1:    row = 40'h00005F0000;
            7'd2:    row = 40'h0007000700;
            7'd3:    row = 40'h147F147F14;
            7'd4:    row = 40'h242A7F2A12;
            7'd5:    row = 40'h2313086462;
            7'd6:    row = 40'h3649562050;
            7'd7:    row = 40'h0008070300;
            7'd8:    row = 40'h001C224100;
            7'd9:    row = 40'h0041221C00;
            7'd10:   row = 40'h2A1C7F1C2A;
            7'd11:   row = 40'h08083E0808;
            7'd12:   row = 40'h0080703000;
            7'd13:   row = 40'h0808080808;
            7'd14:   row = 40'h0000606000;
            7'd15:   row = 40'h2010080402;
            7'd16:   row = 40'h3E5149453E;
            7'd17:   row = 40'h00427F4000;
            7'd18:   row = 40'h7249494946;
            7'd19:   row = 40'h2141494D33;
            7'd20:   row = 40'h1814127F10;
            7'd21:   row = 40'h2745454539;
            7'd22:   row = 40'h3C4A494931;
            7'd23:   row = 40'h4121110907;
            7'd24:   row = 40'h3649494936;
            7'd25:   row = 40'h464949291E;
            7'd26:   row = 40'h0000140000;
            7'd27:   row = 40'h0040340000;
            7'd28:   row = 40'h0008142241;
            7'd29:   row = 40'h1414141414;
            7'd30:   row = 40'h0041221408;
            7'd31:   row = 40'h0201590906;
            7'd32:   row = 40'h3E415D594E;
            7'd33:   row = 40'h7C1211127C;
            7'd34:   row = 40'h7F49494936;
            7'd35:   row = 40'h3E41414122;
            7'd36:   row = 40'h7F4141413E;
            7'd37:   row = 40'h7F49494941;
            7'd38:   row = 40'h7F09090901;
            7'd39:   row = 40'h3E4149497A;
            7'd40:   row = 40'h7F0808087F;
            7'd41:   row = 40'h00417F4100;
            7'd42:   row = 40'h2040413F01;
            7'd43:   row = 40'h7F08142241;
            7'd44:   row = 40'h7F40404040;
            7'd45:   row = 40'h7F021C027F;
            7'd46:   row = 40'h7F0408107F;
            7'd47:   row = 40'h3E4141413E;
            7'd48:   row = 40'h7F09090906;
            7'd49:   row = 40'h3E4151215E;
            7'd50:   row = 40'h7F09192946;
            7'd51:   row = 40'h2649494932;
            7'd52:   row = 40'h03017F0103;
            7'd53:   row = 40'h3F4040403F;
            7'd54:   row = 40'h1F2040201F;
            7'd55:   row = 40'h3F4038403F;
            7'd56:   row = 40'h6314081463;
            7'd57:   row = 40'h0304780403;
            7'd58:   row = 40'h6159494D43;
            7'd65:   row = 40'h2054545478;
            7'd66:   row = 40'h7F48444438;
            7'd67:   row = 40'h3844444420;
            7'd68:   row = 40'h384444487F;
            7'd69:   row = 40'h3854545418;
            7'd70:   row = 40'h087E090102;
            7'd71:   row = 40'h18A4A4A47C;
            7'd72:   row = 40'h7F08040478;
            7'd73:   row = 40'h00447D4000;
            7'd74:   row = 40'h408080807D;
            7'd75:   row = 40'h7F10284400;
            7'd76:   row = 40'h00417F4000;
            7'd77:   row = 40'h7C04180478;
            7'd78:   row = 40'h7C08040478;
            7'd79:   row = 40'h3844444438;
            7'd80:   row = 40'hFC24242418;
            7'd81:   row = 40'h18242418FC;
            7'd82:   row = 40'h7C08040408;
            7'd83:   row = 40'h4854545420;
            7'd84:   row = 40'h043F444020;
            7'd85:   row = 40'h3C4040207C;
            7'd86:   row = 40'h1C2040201C;
            7'd87:   row = 40'h3C4030403C;
            7'd88:   row = 40'h4428102844;
            7'd89:   row = 40'h1CA0A0A07C;
            7'd90:   row = 40'h4464544C44;
            default: row = 40'h0000000000;
        endcase
        return row;
    endfunction

endpackage

// File: rtl/pfte_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module pfte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pfte_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Carries jobs from the front end to the back end and results to the output.
// ----------------------------------------------------------------------------
module pfte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/pfte_front.sv
// ----------------------------------------------------------------------------
// Framebuffer engine front end
// Classifies a command: bounds checks, store address, clipping and glyph index.
// ----------------------------------------------------------------------------
module pfte_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 32
) (
    input  pfte_pkg::t_cmd i_cmd,
    output pfte_pkg::t_job o_job,
    output logic           o_keep
);

    localparam int PAGES = SCREEN_HEIGHT / 8;
    localparam int AXW   = pfte_pkg::ADDR_MAX_W + 1;
    localparam logic [8:0] WIDTH_9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] PAGES_9 = 9'(PAGES);

    logic           col_ok;
    logic           pix_pg_ok;
    logic           chr_pg_ok;
    logic [3:0]     sel_pg;
    logic [AXW-1:0] base;
    logic [8:0]     remain;
    logic [2:0]     ncols;

    always_comb begin
        col_ok    = {1'b0, i_cmd.column} < WIDTH_9;
        pix_pg_ok = {4'b0, i_cmd.row[7:3]} < PAGES_9;
        chr_pg_ok = {1'b0, i_cmd.page} < PAGES_9;
        sel_pg    = (i_cmd.command == pfte_pkg::CMD_PIXEL) ? i_cmd.row[6:3] : i_cmd.page[3:0];
        base      = AXW'(sel_pg) * AXW'(SCREEN_WIDTH) + AXW'(i_cmd.column);
        remain    = WIDTH_9 - {1'b0, i_cmd.column};
        if (!col_ok) begin
            ncols = 3'd0;
        end else if (remain >= 9'(pfte_pkg::GLYPH_COLS)) begin
            ncols = pfte_pkg::GLYPH_COLS;
        end else begin
            ncols = remain[2:0];
        end

        o_job.op      = i_cmd.command;
        o_job.addr    = base[pfte_pkg::ADDR_MAX_W-1:0];
        o_job.mask    = 8'd1 << i_cmd.row[2:0];
        o_job.ncols   = ncols;
        o_job.addr_ok = col_ok && chr_pg_ok;
        if (i_cmd.character inside {[pfte_pkg::FIRST_CODE:pfte_pkg::LAST_CODE]}) begin
            o_job.glyph = pfte_pkg::GLYPH_IDX_W'(i_cmd.character - pfte_pkg::FIRST_CODE);
        end else begin
            o_job.glyph = '0;
        end

        case (i_cmd.command)
            pfte_pkg::CMD_CLEAR: o_keep = 1'b1;
            pfte_pkg::CMD_PIXEL: o_keep = col_ok && pix_pg_ok;
            pfte_pkg::CMD_CHAR:  o_keep = chr_pg_ok && (ncols != 3'd0);
            pfte_pkg::CMD_READ:  o_keep = 1'b1;
            default:             o_keep = 1'b0;
        endcase
    end

endmodule

// File: rtl/pfte_back.sv
// ----------------------------------------------------------------------------
// Framebuffer engine back end
// Executes queued jobs against the single-port frame store and emits reads.
// ----------------------------------------------------------------------------
module pfte_back #(
    parameter int DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfte_pkg::t_job    i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    output pfte_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full,
    output logic              o_init_busy
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    pfte_pkg::t_back_state r_state, n_state;
    pfte_pkg::t_job        r_job, n_job;
    logic [2:0]            r_idx, n_idx;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic                  r_init, n_init;

    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [39:0]   font;
    logic [7:0]    glyph_byte;

    pfte_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        font = pfte_pkg::font_row(r_job.glyph);
        case (r_idx)
            3'd0:    glyph_byte = font[39:32];
            3'd1:    glyph_byte = font[31:24];
            3'd2:    glyph_byte = font[23:16];
            3'd3:    glyph_byte = font[15:8];
            default: glyph_byte = font[7:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_init  = r_init;
        case (r_state)
            pfte_pkg::BK_IDLE: begin
                n_idx = '0;
                n_cnt = '0;
                if (i_job_valid) begin
                    n_job = i_job;
                    case (i_job.op)
                        pfte_pkg::CMD_CLEAR: n_state = pfte_pkg::BK_CLEAR;
                        pfte_pkg::CMD_PIXEL: n_state = pfte_pkg::BK_PIX_WR;
                        pfte_pkg::CMD_CHAR:  n_state = pfte_pkg::BK_CHAR;
                        pfte_pkg::CMD_READ:  n_state = pfte_pkg::BK_RD_DONE;
                        default:             n_state = pfte_pkg::BK_IDLE;
                    endcase
                end
            end
            pfte_pkg::BK_PIX_WR: begin
                n_state = pfte_pkg::BK_IDLE;
            end
            pfte_pkg::BK_RD_DONE: begin
                if (!i_res_full) begin
                    n_state = pfte_pkg::BK_IDLE;
                end
            end
            pfte_pkg::BK_CHAR: begin
                n_idx = r_idx + 3'd1;
                if (r_idx == r_job.ncols - 3'd1) begin
                    n_state = pfte_pkg::BK_IDLE;
                end
            end
            pfte_pkg::BK_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_state = pfte_pkg::BK_IDLE;
                    n_init  = 1'b0;
                end
            end
            default: begin
                n_state = pfte_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_job_pop        = 1'b0;
        o_res_push       = 1'b0;
        o_res.read_data  = r_job.addr_ok ? ram_rdata : 8'd0;
        o_res.address_ok = r_job.addr_ok;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = r_job.addr[AW-1:0];
        ram_wdata        = 8'd0;
        case (r_state)
            pfte_pkg::BK_IDLE: begin
                o_job_pop = i_job_valid;
                ram_en    = i_job_valid;
                ram_addr  = i_job.addr[AW-1:0];
            end
            pfte_pkg::BK_PIX_WR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | r_job.mask;
            end
            pfte_pkg::BK_RD_DONE: begin
                o_res_push = !i_res_full;
            end
            pfte_pkg::BK_CHAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_job.addr[AW-1:0] + AW'(r_idx);
                ram_wdata = glyph_byte;
            end
            pfte_pkg::BK_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = r_cnt;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    assign o_init_busy = r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfte_pkg::BK_CLEAR;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

// File: rtl/page_framebuffer_text_pixel_engine_top.sv
// ----------------------------------------------------------------------------
// Page framebuffer text and pixel engine
// A read result passes the job FIFO, the store read and the result FIFO
// in turn. In the back end a read passes IDLE and RD_DONE, a set pixel
// reads in IDLE and writes back in PIX_WR, and a character writes its
// visible glyph columns one by one in BK_CHAR; all use the one store port.
// A clear zeroes all SCREEN_WIDTH * (SCREEN_HEIGHT / 8) store addresses.
// After reset the same pass runs, and full stays high until it completes.
// ----------------------------------------------------------------------------
module page_framebuffer_text_pixel_engine_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  pfte_pkg::t_cmd    i_cmd,
    output logic              empty,
    input  logic              pop,
    output pfte_pkg::t_result o_result
);

    localparam int DEPTH = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);

    pfte_pkg::t_job    front_job;
    pfte_pkg::t_job    job_head;
    pfte_pkg::t_result back_res;
    logic              keep;
    logic              job_push;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;
    logic              res_push;
    logic              res_full;
    logic              init_busy;

    assign full     = job_full || init_busy;
    assign job_push = push && !full && keep;

    pfte_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_cmd  (i_cmd),
        .o_job  (front_job),
        .o_keep (keep)
    );

    pfte_fifo #(
        .WIDTH ($bits(pfte_pkg::t_job)),
        .DEPTH (2)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    pfte_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_valid (!job_empty),
        .o_job_pop   (job_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_init_busy (init_busy)
    );

    pfte_fifo #(
        .WIDTH ($bits(pfte_pkg::t_result)),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// File: rtl/pfte_checker.sv
// ----------------------------------------------------------------------------
// Framebuffer engine port checker
// Watches the top-level ports for clearing, result and queue behavior.
// ----------------------------------------------------------------------------
`include "page_framebuffer_text_pixel_engine_top_defines.svh"

module pfte_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input pfte_pkg::t_cmd    i_cmd,
    input logic              empty,
    input logic              pop,
    input pfte_pkg::t_result o_result
);

    // The store is swept after reset, so no command is taken right away.
    `PFTE_ASSERT_NOW(a_full_after_reset, i_clk, i_rst_n, $rose(i_rst_n), full)

    // An off-screen read always returns a zero byte.
    `PFTE_ASSERT_NOW(a_off_screen_zero, i_clk, i_rst_n, !empty && !o_result.address_ok, o_result.read_data == 8'd0)

    `PFTE_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, !empty && !pop, !empty)

    `PFTE_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, !empty && !pop, $stable(o_result))

endmodule

bind page_framebuffer_text_pixel_engine_top pfte_checker u_checker (.*);
